/* rtl/core/sft_pkg.sv */
// Shared types, constants and helper functions of the sum formula tokenizer.
package sft_pkg;

  localparam logic [3:0] MAX_SYMBOL_CHARS = 4'd8;
  localparam logic [7:0] MAX_ELEMENTS     = 8'd255;

  // Queue depths are powers of two so that the pointers wrap on their own.
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_UPPER,
    CLS_LOWER,
    CLS_PUNCT,
    CLS_ILLEGAL
  } char_cls_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_PUNCT,
    PH_PDIG,
    PH_PTAIL,
    PH_LET,
    PH_CNT
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_PREFIX,
    ERR_ZERO,
    ERR_EMPTY,
    ERR_ILLEGAL,
    ERR_OVERFLOW
  } err_t;

  typedef struct packed {
    logic [7:0] ch;
    char_cls_t  cls;
    logic       last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [63:0] sym;
    logic [3:0]  len;
    logic [23:0] cnt;
    logic [7:0]  idx;
    err_t        err;
    logic        eof;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [63:0] sym_put(logic [63:0] s, logic [2:0] pos, logic [7:0] c);
    return s | ({56'd0, c} << {pos, 3'b000});
  endfunction

  function automatic result_t token(logic [63:0] s, logic [3:0] len, logic [23:0] cnt,
                                    logic [7:0] idx);
    result_t r;
    r.sym = s;
    r.len = len;
    r.cnt = cnt;
    r.idx = idx;
    r.err = ERR_NONE;
    r.eof = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/core/sft_front.sv */
// Front end: classifies incoming characters and queues them for the tokenizer core.
module sft_front import sft_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       full,
  output head_t      head,
  input  logic       head_pop
);

  item_t            mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FQ_CW-1:0] cnt_r, cnt_nxt;
  char_cls_t        cls;
  logic             wr_ok, rd_ok;

  always_comb begin
    if (in_ch inside {[8'd48:8'd57]}) begin
      cls = CLS_DIGIT;
    end else if (in_ch inside {[8'd65:8'd90]}) begin
      cls = CLS_UPPER;
    end else if (in_ch inside {[8'd97:8'd122]}) begin
      cls = CLS_LOWER;
    end else if (in_ch inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96],
                               [8'd123:8'd126]}) begin
      cls = CLS_PUNCT;
    end else begin
      cls = CLS_ILLEGAL;
    end
  end

  assign full       = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign wr_ok      = push && !full;
  assign rd_ok      = head_pop && head.valid;
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem[rp_r];

  always_comb begin
    wp_nxt  = wr_ok ? wp_r + FQ_AW'(1) : wp_r;
    rp_nxt  = rd_ok ? rp_r + FQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + FQ_CW'(wr_ok) - FQ_CW'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wp_r] <= '{ch: in_ch, cls: cls, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/sft_back.sv */
// Tokenizer core: formula state machine, one character per cycle when room is high.
module sft_back import sft_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  head_t head,
  output logic  head_pop,
  input  logic  room,
  output push_t push_o
);

  phase_t      phase_r, phase_nxt;
  logic [63:0] sym_r, sym_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [23:0] cnt_r, cnt_nxt;
  logic [7:0]  elem_r, elem_nxt;
  err_t        err_r, err_nxt;

  function automatic err_t latch_err(err_t cur, err_t code);
    err_t r;
    r = cur;
    if (cur == ERR_NONE) begin
      r = code;
    end
    return r;
  endfunction

  // The core only moves when the result queue can take two results.
  assign head_pop = head.valid && room;

  always_comb begin
    logic [7:0]  c;
    char_cls_t   cls;
    logic        redo;
    logic        temit;
    logic [27:0] cnt_w;
    result_t     res0, res1, tt;
    logic [1:0]  n;

    c         = head.item.ch;
    cls       = head.item.cls;
    redo      = 1'b0;
    temit     = 1'b0;
    cnt_w     = '0;
    res0      = '0;
    res1      = '0;
    tt        = '0;
    n         = 2'd0;
    phase_nxt = phase_r;
    sym_nxt   = sym_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    elem_nxt  = elem_r;
    err_nxt   = err_r;

    // Character pass.
    if (err_nxt == ERR_NONE) begin
      case (phase_r)
        PH_PUNCT: begin
          if (cls == CLS_DIGIT) begin
            if (len_nxt >= MAX_SYMBOL_CHARS) begin
              err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
            end else begin
              sym_nxt   = sym_put(sym_nxt, len_nxt[2:0], c);
              len_nxt   = len_nxt + 4'd1;
              phase_nxt = PH_PDIG;
            end
          end else begin
            // A lone punctuation mark is dropped and the character starts afresh.
            sym_nxt   = '0;
            len_nxt   = '0;
            phase_nxt = PH_START;
            redo      = 1'b1;
          end
        end
        PH_PDIG: begin
          if (len_nxt >= MAX_SYMBOL_CHARS) begin
            err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
          end else begin
            sym_nxt = sym_put(sym_nxt, len_nxt[2:0], c);
            len_nxt = len_nxt + 4'd1;
            if (cls != CLS_DIGIT) begin
              phase_nxt = PH_PTAIL;
            end
          end
        end
        PH_PTAIL: begin
          if (cls != CLS_UPPER && cls != CLS_LOWER) begin
            err_nxt = latch_err(err_nxt, ERR_PREFIX);
          end else if (len_nxt >= MAX_SYMBOL_CHARS) begin
            err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
          end else begin
            sym_nxt   = sym_put(sym_nxt, len_nxt[2:0], c);
            len_nxt   = len_nxt + 4'd1;
            phase_nxt = PH_LET;
          end
        end
        PH_LET: begin
          case (cls)
            CLS_UPPER: begin
              if (elem_nxt >= MAX_ELEMENTS) begin
                err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
              end else begin
                elem_nxt = elem_nxt + 8'd1;
                res0     = token(sym_nxt, len_nxt, 24'd1, elem_nxt);
                n        = 2'd1;
                sym_nxt  = {56'd0, c};
                len_nxt  = 4'd1;
              end
            end
            CLS_LOWER: begin
              if (len_nxt >= MAX_SYMBOL_CHARS) begin
                err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
              end else begin
                sym_nxt = sym_put(sym_nxt, len_nxt[2:0], c);
                len_nxt = len_nxt + 4'd1;
              end
            end
            CLS_DIGIT: begin
              cnt_nxt   = {20'd0, c[3:0]};
              phase_nxt = PH_CNT;
            end
            default: begin
              if (elem_nxt >= MAX_ELEMENTS) begin
                err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
              end else begin
                elem_nxt  = elem_nxt + 8'd1;
                res0      = token(sym_nxt, len_nxt, 24'd1, elem_nxt);
                n         = 2'd1;
                sym_nxt   = '0;
                len_nxt   = '0;
                phase_nxt = PH_START;
                redo      = 1'b1;
              end
            end
          endcase
        end
        PH_CNT: begin
          if (cls == CLS_DIGIT) begin
            cnt_w = {1'b0, cnt_nxt, 3'b000} + {3'b000, cnt_nxt, 1'b0} + {24'd0, c[3:0]};
            if (cnt_w[27:24] != 4'd0) begin
              err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
            end
            cnt_nxt = cnt_w[23:0];
          end else if (cnt_nxt == 24'd0) begin
            err_nxt = latch_err(err_nxt, ERR_ZERO);
          end else if (elem_nxt >= MAX_ELEMENTS) begin
            err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
          end else begin
            elem_nxt  = elem_nxt + 8'd1;
            res0      = token(sym_nxt, len_nxt, cnt_nxt, elem_nxt);
            n         = 2'd1;
            sym_nxt   = '0;
            len_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_START;
            redo      = 1'b1;
          end
        end
        default: begin
          redo = 1'b1;
        end
      endcase

      // Token start, also reached when a finished token hands its character on.
      if (redo) begin
        if (cls == CLS_PUNCT) begin
          sym_nxt   = {56'd0, c};
          len_nxt   = 4'd1;
          phase_nxt = PH_PUNCT;
        end else if (cls == CLS_UPPER || cls == CLS_LOWER) begin
          sym_nxt   = {56'd0, c};
          len_nxt   = 4'd1;
          phase_nxt = PH_LET;
        end else begin
          err_nxt = latch_err(err_nxt, ERR_ILLEGAL);
        end
      end
    end

    // Closing pass on the final character.
    if (head.item.last) begin
      if (err_nxt == ERR_NONE) begin
        case (phase_nxt)
          PH_PUNCT: begin
          end
          PH_PDIG, PH_PTAIL: begin
            err_nxt = latch_err(err_nxt, ERR_PREFIX);
          end
          PH_LET: begin
            if (elem_nxt >= MAX_ELEMENTS) begin
              err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
            end else begin
              elem_nxt = elem_nxt + 8'd1;
              tt       = token(sym_nxt, len_nxt, 24'd1, elem_nxt);
              temit    = 1'b1;
            end
          end
          PH_CNT: begin
            if (cnt_nxt == 24'd0) begin
              err_nxt = latch_err(err_nxt, ERR_ZERO);
            end else if (elem_nxt >= MAX_ELEMENTS) begin
              err_nxt = latch_err(err_nxt, ERR_OVERFLOW);
            end else begin
              elem_nxt = elem_nxt + 8'd1;
              tt       = token(sym_nxt, len_nxt, cnt_nxt, elem_nxt);
              temit    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (temit) begin
        if (n == 2'd0) begin
          res0 = tt;
        end else begin
          res1 = tt;
        end
        n = n + 2'd1;
      end

      if (err_nxt == ERR_NONE && elem_nxt == 8'd0) begin
        err_nxt = ERR_EMPTY;
      end

      if (err_nxt == ERR_NONE && n != 2'd0) begin
        if (n == 2'd1) begin
          res0.eof = 1'b1;
        end else begin
          res1.eof = 1'b1;
        end
      end else begin
        tt     = '0;
        tt.idx = elem_nxt;
        tt.err = err_nxt;
        tt.eof = 1'b1;
        if (n == 2'd0) begin
          res0 = tt;
        end else begin
          res1 = tt;
        end
        n = n + 2'd1;
      end

      phase_nxt = PH_START;
      sym_nxt   = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      elem_nxt  = '0;
      err_nxt   = ERR_NONE;
    end

    push_o.n      = head_pop ? n : 2'd0;
    push_o.first  = res0;
    push_o.second = res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      sym_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      elem_r  <= '0;
      err_r   <= ERR_NONE;
    end else if (head_pop) begin
      phase_r <= phase_nxt;
      sym_r   <= sym_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      elem_r  <= elem_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* rtl/core/sft_outq.sv */
// Result queue: takes up to two results per cycle and hands them out one at a time.
module sft_outq import sft_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push_i,
  output logic    room,
  input  logic    pop,
  output logic    empty,
  output result_t head
);

  result_t          mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             rd_ok;

  assign room  = (cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign empty = (cnt_r == '0);
  assign rd_ok = pop && !empty;
  assign head  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + OQ_AW'(push_i.n);
    rp_nxt  = rd_ok ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + OQ_CW'(push_i.n) - OQ_CW'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (push_i.n != 2'd0) begin
      mem[wp_r] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem[wp_r + OQ_AW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/sum_formula_tokenizer_top.sv */
// Top level of the chemical sum formula tokenizer.
//
// Characters of a formula enter through a queue-like port: a request is taken
// at a clock edge where push is high and full is low; in_last marks the final
// character of a formula. Each element found comes out as one result with its
// symbol text, length, atom count and index; the final character also closes
// the formula, either by flagging its own token with out_end_of_formula or by
// an extra end result that carries the element total and any error code.
// Results are read like a queue: while empty is low the oldest result is on
// the out_ ports, and it is taken at an edge where pop is high.
// A result passes through the input queue and the result queue before it is taken.
// The core takes one character per cycle whenever the result queue has room
// for two results, so the sustained rate is one character per cycle as long
// as results are drained as fast as they are made; a character that yields
// two results needs two pops. A four-entry queue in front lets the
// sender keep pushing while results wait. A stalled receiver fills the result
// queue, then the input queue, and full rises; nothing is lost.
// Synchronous reset clears both queues and the parser state.
module sum_formula_tokenizer_top import sft_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_symbol_bytes,
  output logic [3:0]  out_symbol_len,
  output logic [23:0] out_atom_count,
  output logic [7:0]  out_element_index,
  output logic [2:0]  out_error_code,
  output logic        out_end_of_formula
);

  head_t   head;
  logic    head_pop;
  logic    room;
  push_t   res_push;
  result_t res_head;

  sft_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .full     (full),
    .head     (head),
    .head_pop (head_pop)
  );

  sft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_pop (head_pop),
    .room     (room),
    .push_o   (res_push)
  );

  sft_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (res_push),
    .room   (room),
    .pop    (pop),
    .empty  (empty),
    .head   (res_head)
  );

  assign out_symbol_bytes   = res_head.sym;
  assign out_symbol_len     = res_head.len;
  assign out_atom_count     = res_head.cnt;
  assign out_element_index  = res_head.idx;
  assign out_error_code     = res_head.err;
  assign out_end_of_formula = res_head.eof;

endmodule

/* tb/sv/tb_sum_formula_tokenizer_top.sv */
// Self-checking testbench for the sum formula tokenizer top level.
`timescale 1ns / 1ps

module tb_sum_formula_tokenizer_top import sft_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES = 1900;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_FROM = 800;
  localparam int QUIET_TO = 1100;
  localparam int DRAIN_AT = 1200;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } formula_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  in_ch = 8'd0;
  logic        in_last = 1'b0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_symbol_bytes;
  logic [3:0]  out_symbol_len;
  logic [23:0] out_atom_count;
  logic [7:0]  out_element_index;
  logic [2:0]  out_error_code;
  logic        out_end_of_formula;

  formula_byte_t formula_bytes[$];
  logic [7:0]    draft[$];
  result_t       expected_tokens[$];

  int cyc = 0;
  int accepted = 0;
  int mismatch_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Parser state as the tokenizer should hold it.
  phase_t      ps_phase;
  logic [63:0] ps_sym;
  int          ps_len;
  int unsigned ps_count;
  int          ps_elems;
  err_t        ps_err;
  result_t     step_tok[2];
  int          step_n;

  sum_formula_tokenizer_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .in_ch              (in_ch),
    .in_last            (in_last),
    .full               (full),
    .empty              (empty),
    .pop                (pop),
    .out_symbol_bytes   (out_symbol_bytes),
    .out_symbol_len     (out_symbol_len),
    .out_atom_count     (out_atom_count),
    .out_element_index  (out_element_index),
    .out_error_code     (out_error_code),
    .out_end_of_formula (out_end_of_formula)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic bit is_upper(logic [7:0] c);
    return c >= 8'd65 && c <= 8'd90;
  endfunction

  function automatic bit is_lower(logic [7:0] c);
    return c >= 8'd97 && c <= 8'd122;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic void reset_parser();
    ps_phase = PH_START;
    ps_sym = 64'd0;
    ps_len = 0;
    ps_count = 0;
    ps_elems = 0;
    ps_err = ERR_NONE;
  endfunction

  function automatic void clear_sym();
    ps_sym = 64'd0;
    ps_len = 0;
  endfunction

  // Only the first error of a formula is kept.
  function automatic void latch_err(err_t e);
    if (ps_err == ERR_NONE) ps_err = e;
  endfunction

  function automatic void put_tok(logic [63:0] sym, int len, int unsigned cnt, int idx,
                                  err_t e, bit eof);
    result_t r;
    r.sym = sym;
    r.len = 4'(len);
    r.cnt = 24'(cnt);
    r.idx = 8'(idx);
    r.err = e;
    r.eof = eof;
    if (step_n < 2) begin
      step_tok[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic bit append_sym(logic [7:0] c);
    if (ps_len >= int'(MAX_SYMBOL_CHARS)) begin
      latch_err(ERR_OVERFLOW);
      return 1'b0;
    end
    ps_sym = ps_sym | ({56'd0, c} << (8 * ps_len));
    ps_len++;
    return 1'b1;
  endfunction

  function automatic bit emit_element(int unsigned cnt);
    if (ps_elems >= int'(MAX_ELEMENTS)) begin
      latch_err(ERR_OVERFLOW);
      return 1'b0;
    end
    ps_elems++;
    put_tok(ps_sym, ps_len, cnt, ps_elems, ERR_NONE, 1'b0);
    clear_sym();
    return 1'b1;
  endfunction

  // One character, or the close of the formula when term is set. Some phases
  // hand the same character on to the token start, hence the loop.
  function automatic void parse_char(logic [7:0] c, bit term);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (ps_phase)
        PH_PUNCT: begin
          if (!term && is_digit(c)) begin
            if (append_sym(c)) ps_phase = PH_PDIG;
          end else begin
            clear_sym();
            ps_phase = PH_START;
            again = !term;
          end
        end
        PH_PDIG: begin
          if (term) latch_err(ERR_PREFIX);
          else if (append_sym(c) && !is_digit(c)) ps_phase = PH_PTAIL;
        end
        PH_PTAIL: begin
          if (term || !is_alpha(c)) latch_err(ERR_PREFIX);
          else if (append_sym(c)) ps_phase = PH_LET;
        end
        PH_LET: begin
          if (term) begin
            if (emit_element(1)) ps_phase = PH_START;
          end else if (is_upper(c)) begin
            if (emit_element(1)) void'(append_sym(c));
          end else if (is_lower(c)) begin
            void'(append_sym(c));
          end else if (is_digit(c)) begin
            ps_count = c - 8'd48;
            ps_phase = PH_CNT;
          end else if (emit_element(1)) begin
            ps_phase = PH_START;
            again = 1'b1;
          end
        end
        PH_CNT: begin
          if (!term && is_digit(c)) begin
            ps_count = ps_count * 10 + (c - 8'd48);
            if (ps_count > 32'h00FF_FFFF) latch_err(ERR_OVERFLOW);
          end else if (ps_count == 0) begin
            latch_err(ERR_ZERO);
          end else if (emit_element(ps_count)) begin
            ps_count = 0;
            ps_phase = PH_START;
            again = !term;
          end
        end
        default: begin
          if (!term) begin
            if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
              clear_sym();
              if (append_sym(c)) ps_phase = PH_PUNCT;
            end else if (is_alpha(c)) begin
              clear_sym();
              if (append_sym(c)) ps_phase = PH_LET;
            end else begin
              latch_err(ERR_ILLEGAL);
            end
          end
        end
      endcase
    end
  endfunction

  // Works out the tokens one accepted request causes and queues them.
  function automatic void predict_tokens(formula_byte_t fb);
    step_n = 0;
    if (ps_err == ERR_NONE) parse_char(fb.ch, 1'b0);
    if (fb.last) begin
      if (ps_err == ERR_NONE) parse_char(8'd0, 1'b1);
      if (ps_err == ERR_NONE && ps_elems == 0) ps_err = ERR_EMPTY;
      if (ps_err == ERR_NONE && step_n > 0) step_tok[step_n - 1].eof = 1'b1;
      else put_tok(64'd0, 0, 0, ps_elems, ps_err, 1'b1);
      reset_parser();
    end
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_tok[i]);
  endfunction

  function automatic logic [7:0] rand_punct();
    int r;
    r = $urandom_range(0, 31);
    if (r < 15) return 8'(33 + r);
    else if (r < 22) return 8'(58 + r - 15);
    else if (r < 28) return 8'(91 + r - 22);
    else return 8'(123 + r - 28);
  endfunction

  function automatic void draft_str(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endfunction

  // Moves the drafted formula into the request queue, last set on its final byte.
  function automatic void commit_draft();
    formula_byte_t fb;
    for (int i = 0; i < draft.size(); i++) begin
      fb.ch = draft[i];
      fb.last = (i == draft.size() - 1);
      formula_bytes.push_back(fb);
    end
    draft.delete();
  endfunction

  function automatic void draft_random_formula();
    int kind;
    int n_el;
    int nl;
    int r;
    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      // Punctuation alone never yields an element.
      repeat ($urandom_range(1, 3)) draft.push_back(rand_punct());
      return;
    end
    n_el = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
    repeat (n_el) begin
      if ($urandom_range(0, 9) == 0) begin
        draft.push_back(rand_punct());
        repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(48, 57)));
        draft.push_back($urandom_range(0, 1) ? rand_punct() : 8'($urandom_range(65, 90)));
      end
      draft.push_back(8'($urandom_range(65, 90)));
      nl = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 8) : $urandom_range(0, 1);
      repeat (nl) draft.push_back(8'($urandom_range(97, 122)));
      case ($urandom_range(0, 9))
        5, 6, 7: draft_str($sformatf("%0d", $urandom_range(1, 999)));
        8: begin
          r = $urandom_range(0, 3);
          if (r == 0) draft_str("16777215");
          else if (r == 1) draft_str("16777216");
          else if (r == 2) draft_str($sformatf("%0d", $urandom_range(1000, 16777215)));
          else draft_str($sformatf("%0d", $urandom));
        end
        9: begin
          r = $urandom_range(0, 2);
          if (r == 0) draft_str("0");
          else if (r == 1) draft_str("00");
          else draft_str("07");
        end
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) draft.push_back(rand_punct());
    end
    if (kind < 8) begin
      // The formula stops inside an isotope prefix.
      draft.push_back(rand_punct());
      draft.push_back(8'($urandom_range(48, 57)));
    end else if (kind < 12) begin
      // A prefix tail followed by something other than a letter.
      draft.push_back(rand_punct());
      draft.push_back(8'($urandom_range(48, 57)));
      draft.push_back(rand_punct());
      draft.push_back($urandom_range(0, 1) ? rand_punct() : 8'($urandom_range(48, 57)));
    end else if (kind < 22) begin
      draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_cnt < 40)
      $display("cycle %0d: %s got %h want %h", cyc, what, got, want);
    mismatch_cnt++;
  endtask

  // Sender: at falling edges offers the head of the request queue or idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (formula_bytes.size() == 0) begin
      push <= 1'b0;
    end else if (accepted == DRAIN_AT && expected_tokens.size() != 0) begin
      push <= 1'b0;
    end else if (!(accepted >= QUIET_FROM && accepted < QUIET_TO) &&
                 $urandom_range(0, 99) < 10) begin
      push <= 1'b0;
    end else begin
      push <= 1'b1;
      in_ch <= formula_bytes[0].ch;
      in_last <= formula_bytes[0].last;
    end
  end

  // Receiver: random idling plus one long hold-off while requests keep coming.
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= (accepted >= QUIET_FROM && accepted < QUIET_TO) || $urandom_range(0, 99) >= 10;
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin
    result_t want;
    cyc <= cyc + 1;
    if (rst_n) begin
      if (push && !full) begin
        predict_tokens(formula_bytes[0]);
        void'(formula_bytes.pop_front());
        accepted <= accepted + 1;
      end
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("result with none expected, symbol_bytes", out_symbol_bytes, 64'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (out_symbol_bytes !== want.sym)
            report_mismatch("symbol_bytes", out_symbol_bytes, want.sym);
          if (out_symbol_len !== want.len)
            report_mismatch("symbol_len", out_symbol_len, want.len);
          if (out_atom_count !== want.cnt)
            report_mismatch("atom_count", out_atom_count, want.cnt);
          if (out_element_index !== want.idx)
            report_mismatch("element_index", out_element_index, want.idx);
          if (out_error_code !== want.err)
            report_mismatch("error_code", out_error_code, want.err);
          if (out_end_of_formula !== want.eof)
            report_mismatch("end_of_formula", out_end_of_formula, want.eof);
        end
      end
    end
  end

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("sum_formula_tokenizer_top verification failed");
    $finish;
  end

  initial begin
    int n_long;
    int target;
    n_long = 0;
    reset_parser();

    // Directed formulas: plain, isotope prefix, zero count, empty, illegal byte,
    // count without a symbol, cut-off prefix and an overlong symbol.
    draft_str("H2O");
    commit_draft();
    draft_str("[13]C");
    commit_draft();
    draft_str("H0");
    commit_draft();
    draft_str("+");
    commit_draft();
    draft.push_back(8'hFF);
    commit_draft();
    draft_str("5");
    commit_draft();
    draft_str("[1");
    commit_draft();
    draft_str("Abcdefghi");
    commit_draft();

    target = formula_bytes.size() + RANDOM_BYTES;
    while (formula_bytes.size() < target) begin
      // Two long runs of single-letter elements: the element limit exactly,
      // then one past it.
      if (n_long < 2 && formula_bytes.size() > 700 * (n_long + 1)) begin
        repeat (int'(MAX_ELEMENTS) + n_long) draft.push_back(8'($urandom_range(65, 90)));
        n_long++;
      end else begin
        draft_random_formula();
      end
      commit_draft();
    end

    wait (rst_n);
    while (formula_bytes.size() != 0) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_tokens.size() == 0) begin
      $display("sum_formula_tokenizer_top verification clean");
    end else begin
      $display("sum_formula_tokenizer_top verification failed");
    end
    $finish;
  end

endmodule
